// ===== rtl/mcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

    // Request opcodes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_RUN    = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_TICK   = 3'd5;

    // Command kinds held in the table
    localparam logic [1:0] KIND_MOVE = 2'd0;
    localparam logic [1:0] KIND_WAIT = 2'd1;
    localparam logic [1:0] KIND_LOOP = 2'd2;

    // Result events
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_REJECT = 2'd1;
    localparam logic [1:0] EV_MOVE   = 2'd2;
    localparam logic [1:0] EV_DONE   = 2'd3;

    localparam int VALUE_W = 23;
    localparam int ENTRY_W = 25;

    localparam logic [9:0]  SETTLE_RESET = 10'd100;
    localparam logic [15:0] SAT16        = 16'hFFFF;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the accepted input beat
        logic exec;       // decode cycle: run edits, run, stop; issue step read
        logic tick;       // evaluate the current step with the read entry
        logic shift;      // step of the remove shift-down
        logic load_out;   // move the result into the output register
    } mcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       remove_ok;
        logic       shift_done;
    } mcs_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mcs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcs_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/mcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcs_ctrl
    import mcs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output mcs_cmd_t      cmd,
    input  wire mcs_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_SHIFT,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Drive datapath commands from the current state
    always_comb begin
        cmd          = '0;
        cmd.latch    = accept;
        cmd.exec     = (state_reg == ST_DECODE);
        cmd.tick     = (state_reg == ST_TICK);
        cmd.shift    = (state_reg == ST_SHIFT);
        cmd.load_out = (state_reg == ST_RESP) && out_free;
    end

    // Sequence one request and hand the result to the output register
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.op == OP_TICK) begin
                    state_next = ST_TICK;
                end else if (sts.op == OP_REMOVE && sts.remove_ok) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_TICK: begin
                state_next = ST_RESP;
            end
            ST_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // An accepted beat always goes to decode next
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_DECODE)
        else $error("accepted beat did not enter decode");

    // A loaded result shows up as a valid output beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result load lost");

    // Shift continues until the datapath reports it finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && !sts.shift_done) |=> state_reg == ST_SHIFT)
        else $error("shift left early");

endmodule

`default_nettype wire

// ===== rtl/mcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcs_datapath
    import mcs_pkg::*;
#(
    parameter int MAX_COMMANDS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wen,
    input  wire logic [9:0]         cfg_wdata,
    input  wire logic [2:0]         in_opcode,
    input  wire logic [1:0]         in_kind,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire logic [5:0]         in_index,
    input  wire logic [9:0]         in_tick,
    input  wire logic               in_reached,
    input  wire mcs_cmd_t           cmd,
    output mcs_sts_t                sts,
    output logic [1:0]              out_event,
    output logic [VALUE_W-1:0]      out_target,
    output logic                    out_running,
    output logic [6:0]              out_step,
    output logic [6:0]              out_count,
    output logic [15:0]             out_loops
);

    localparam int CNT_W = $clog2(MAX_COMMANDS + 1);
    localparam int AW    = $clog2(MAX_COMMANDS);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COMMANDS);

    // Latched request
    logic [2:0]         op_reg;
    logic [1:0]         kind_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [5:0]         idx_reg;
    logic [9:0]         tick_reg;
    logic               reach_reg;

    // Sequencer state
    logic [CNT_W-1:0]   total_reg,   total_next;
    logic [CNT_W-1:0]   ptr_reg,     ptr_next;
    logic [15:0]        tally_reg,   tally_next;
    logic               active_reg,  active_next;
    logic               begun_reg,   begun_next;
    logic [15:0]        elapsed_reg, elapsed_next;
    logic [9:0]         settle_reg;

    // Shift-down pointers and pending result
    logic [CNT_W-1:0]   rptr_reg,    rptr_next;
    logic               pend_reg,    pend_next;
    logic [1:0]         ev_reg,      ev_next;
    logic [VALUE_W-1:0] tgt_reg,     tgt_next;

    // Output payload
    logic [1:0]         m_event_reg;
    logic [VALUE_W-1:0] m_target_reg;
    logic               m_running_reg;
    logic [6:0]         m_step_reg;
    logic [6:0]         m_count_reg;
    logic [15:0]        m_loops_reg;

    // Store access
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [CNT_W-1:0]   wr_back;

    // Decode helpers
    logic               append_ok;
    logic               remove_ok;
    logic [CNT_W-1:0]   rptr_init;
    logic [1:0]         e_kind;
    logic [VALUE_W-1:0] e_val;
    logic [16:0]        sum17;
    logic [15:0]        sum_sat;
    logic [15:0]        wait_elapsed;
    logic [15:0]        need;
    logic               val_zero;
    logic               val_pos;
    logic               tally_lt;

    assign append_ok = !active_reg && (total_reg < MAX_CNT)
                       && (kind_reg == KIND_MOVE || kind_reg == KIND_WAIT
                           || kind_reg == KIND_LOOP);
    assign remove_ok = !active_reg && (CMP_W'(idx_reg) < CMP_W'(total_reg));
    assign rptr_init = CNT_W'(CMP_W'(idx_reg) + CMP_W'(1));
    assign wr_back   = rptr_reg - CNT_W'(2);

    assign sts.op         = op_reg;
    assign sts.remove_ok  = remove_ok;
    assign sts.shift_done = !pend_reg && (rptr_reg >= total_reg);

    // Entry fields and step arithmetic
    assign e_kind       = ram_rdata[ENTRY_W-1:VALUE_W];
    assign e_val        = ram_rdata[VALUE_W-1:0];
    assign sum17        = {1'b0, elapsed_reg} + {7'b0, tick_reg};
    assign sum_sat      = sum17[16] ? SAT16 : sum17[15:0];
    assign wait_elapsed = begun_reg ? sum_sat : 16'd0;
    assign val_zero     = (e_val == '0);
    assign val_pos      = !e_val[VALUE_W-1] && !val_zero;
    assign tally_lt     = {7'b0, tally_reg} < e_val;

    // Clamp a wait time to the elapsed counter range
    always_comb begin
        if (e_val[VALUE_W-1]) begin
            need = 16'd0;
        end else if (|e_val[VALUE_W-2:16]) begin
            need = SAT16;
        end else begin
            need = e_val[15:0];
        end
    end

    // Store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = total_reg[AW-1:0];
        ram_wdata = {kind_reg, val_reg};
        ram_raddr = ptr_reg[AW-1:0];
        if (cmd.exec && op_reg == OP_APPEND && append_ok) begin
            ram_we = 1'b1;
        end
        if (cmd.shift) begin
            ram_raddr = rptr_reg[AW-1:0];
            ram_we    = pend_reg;
            ram_waddr = wr_back[AW-1:0];
            ram_wdata = ram_rdata;
        end
    end

    // Next state of the sequencer
    always_comb begin
        total_next   = total_reg;
        ptr_next     = ptr_reg;
        tally_next   = tally_reg;
        active_next  = active_reg;
        begun_next   = begun_reg;
        elapsed_next = elapsed_reg;
        rptr_next    = rptr_reg;
        pend_next    = pend_reg;
        ev_next      = ev_reg;
        tgt_next     = tgt_reg;

        if (cmd.exec) begin
            ev_next  = EV_NONE;
            tgt_next = '0;
            case (op_reg)
                OP_APPEND: begin
                    if (append_ok) begin
                        total_next = total_reg + CNT_W'(1);
                    end else begin
                        ev_next = EV_REJECT;
                    end
                end
                OP_REMOVE: begin
                    if (remove_ok) begin
                        rptr_next = rptr_init;
                        pend_next = 1'b0;
                    end else begin
                        ev_next = EV_REJECT;
                    end
                end
                OP_CLEAR: begin
                    if (active_reg) begin
                        ev_next = EV_REJECT;
                    end else begin
                        total_next = '0;
                    end
                end
                OP_RUN: begin
                    if (active_reg || total_reg == '0) begin
                        ev_next = EV_REJECT;
                    end else begin
                        ptr_next     = '0;
                        tally_next   = '0;
                        active_next  = 1'b1;
                        begun_next   = 1'b0;
                        elapsed_next = '0;
                    end
                end
                OP_STOP: begin
                    active_next = 1'b0;
                end
                default: begin
                end
            endcase
        end

        // Evaluate the current step
        if (cmd.tick && active_reg) begin
            if (ptr_reg >= total_reg) begin
                active_next = 1'b0;
                ev_next     = EV_DONE;
            end else begin
                case (e_kind)
                    KIND_MOVE: begin
                        if (!begun_reg) begin
                            begun_next   = 1'b1;
                            elapsed_next = '0;
                            tgt_next     = e_val;
                            ev_next      = EV_MOVE;
                        end else begin
                            elapsed_next = sum_sat;
                            if (sum_sat > {6'b0, settle_reg} && reach_reg) begin
                                begun_next = 1'b0;
                                ptr_next   = ptr_reg + CNT_W'(1);
                            end
                        end
                    end
                    KIND_WAIT: begin
                        begun_next   = 1'b1;
                        elapsed_next = wait_elapsed;
                        if (wait_elapsed >= need) begin
                            begun_next = 1'b0;
                            ptr_next   = ptr_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                        if (val_zero || (val_pos && tally_lt)) begin
                            ptr_next   = '0;
                            begun_next = 1'b0;
                            if (tally_reg != SAT16) begin
                                tally_next = tally_reg + 16'd1;
                            end
                        end else begin
                            ptr_next = ptr_reg + CNT_W'(1);
                        end
                    end
                endcase
            end
        end

        // Shift entries down one per cycle behind the read
        if (cmd.shift) begin
            pend_next = (rptr_reg < total_reg);
            if (rptr_reg < total_reg) begin
                rptr_next = rptr_reg + CNT_W'(1);
            end
            if (!pend_reg && rptr_reg >= total_reg) begin
                total_next = total_reg - CNT_W'(1);
            end
        end
    end

    // Capture the request beat
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= in_opcode;
            kind_reg  <= in_kind;
            val_reg   <= in_value;
            idx_reg   <= in_index;
            tick_reg  <= in_tick;
            reach_reg <= in_reached;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            ptr_reg     <= '0;
            tally_reg   <= '0;
            active_reg  <= 1'b0;
            begun_reg   <= 1'b0;
            elapsed_reg <= '0;
            settle_reg  <= SETTLE_RESET;
            pend_reg    <= 1'b0;
        end else begin
            total_reg   <= total_next;
            ptr_reg     <= ptr_next;
            tally_reg   <= tally_next;
            active_reg  <= active_next;
            begun_reg   <= begun_next;
            elapsed_reg <= elapsed_next;
            pend_reg    <= pend_next;
            if (cfg_wen) begin
                settle_reg <= cfg_wdata;
            end
        end
    end

    // Working payload and output register
    always_ff @(posedge aclk) begin
        rptr_reg <= rptr_next;
        ev_reg   <= ev_next;
        tgt_reg  <= tgt_next;
        if (cmd.load_out) begin
            m_event_reg   <= ev_reg;
            m_target_reg  <= (ev_reg == EV_MOVE) ? tgt_reg : '0;
            m_running_reg <= active_reg;
            m_step_reg    <= 7'(ptr_reg);
            m_count_reg   <= 7'(total_reg);
            m_loops_reg   <= tally_reg;
        end
    end

    assign out_event   = m_event_reg;
    assign out_target  = m_target_reg;
    assign out_running = m_running_reg;
    assign out_step    = m_step_reg;
    assign out_count   = m_count_reg;
    assign out_loops   = m_loops_reg;

    mcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COMMANDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Table never grows past its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= MAX_CNT)
        else $error("command count beyond capacity");

    // Table is frozen while the sequence runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |=> total_reg == $past(total_reg))
        else $error("table edited while running");

    // Running step never passes the end of the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> ptr_reg <= total_reg)
        else $error("step pointer beyond table");

endmodule

`default_nettype wire

// ===== rtl/motion_command_sequencer.sv =====
// Sequencing: an accepted request beat is decoded; a tick then evaluates the current step, and a
//   valid remove shifts the n = entry_count - entry_index - 1 later entries down one per cycle
//   behind the read; the result is then loaded into the output register once it is free.
// Throughput: one request at a time; the next beat is taken the cycle after the
//   result is registered.
// Reset (aresetn low, synchronous): table empty, sequence stopped, counters zero,
//   settle_ms back to 100; table contents are left as they are, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module motion_command_sequencer
    import mcs_pkg::*;
#(
    parameter int MAX_COMMANDS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [9:0]  cfg_wdata,   // settle_ms
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,     // cmd_value[22:0], entry_index[28:23],
                                          // tick_ms[38:29], target_reached[39]
    input  wire logic [4:0]  s_tuser,     // opcode[2:0], cmd_kind[4:3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,     // move_target[22:0], running[23],
                                          // current_step[30:24], entry_count[37:31],
                                          // loops_done[53:38], zero[55:54]
    output logic [1:0]       m_tuser      // event_res[1:0]
);

    mcs_cmd_t           cmd;
    mcs_sts_t           sts;
    logic [VALUE_W-1:0] out_target;
    logic               out_running;
    logic [6:0]         out_step;
    logic [6:0]         out_count;
    logic [15:0]        out_loops;

    mcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mcs_datapath #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_opcode   (s_tuser[2:0]),
        .in_kind     (s_tuser[4:3]),
        .in_value    (s_tdata[22:0]),
        .in_index    (s_tdata[28:23]),
        .in_tick     (s_tdata[38:29]),
        .in_reached  (s_tdata[39]),
        .cmd         (cmd),
        .sts         (sts),
        .out_event   (m_tuser),
        .out_target  (out_target),
        .out_running (out_running),
        .out_step    (out_step),
        .out_count   (out_count),
        .out_loops   (out_loops)
    );

    // Pack the result beat
    assign m_tdata = {2'b00, out_loops, out_count, out_step, out_running, out_target};

endmodule

`default_nettype wire
